FILE: design/qrs_pkg.sv
`timescale 1ns / 1ps
// Shared types for the quadratic root solver.
// No dependencies.
package qrs_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_INF  = 2'd3
  } kind_e;

  // travels with the radicand through the square root
  typedef struct packed {
    kind_e kind;
    logic  a_neg;
    logic  b_neg;
    logic  c_neg;
  } sq_side_t;

  // travels with the first quotient through its divider
  typedef struct packed {
    kind_e kind;
    logic  low_neg;
  } dv_side_t;

endpackage

FILE: design/qrs_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, floor result.
// Carries a sideband vector alongside each request. No package use.
module qrs_sqrt #(
  parameter int RootW = 33,
  parameter int SideW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2*RootW-1:0]   rad_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic [RootW-1:0]     root_o,
  output logic [SideW-1:0]     side_o
);

  logic                 vld_q  [RootW];
  logic [RootW+1:0]     rem_q  [RootW];
  logic [RootW-1:0]     root_q [RootW];
  logic [2*RootW-1:0]   rad_q  [RootW];
  logic [SideW-1:0]     side_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic               vld_in;
    logic [RootW+1:0]   rem_in;
    logic [RootW-1:0]   root_in;
    logic [2*RootW-1:0] rad_in;
    logic [SideW-1:0]   side_in;
    logic [RootW+2:0]   t;
    logic [RootW+2:0]   trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign t     = {rem_in[RootW:0], rad_in[2*RootW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (RootW+2)'(t - trial) : (RootW+2)'(t);
        root_q[k] <= {root_in[RootW-2:0], ge};
        rad_q[k]  <= rad_in << 2;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

FILE: design/qrs_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Carries a sideband vector alongside each request. No package use.
module qrs_div #(
  parameter int NumW  = 49,
  parameter int DenW  = 33,
  parameter int SideW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [DenW-1:0]   den_i,
  input  logic [SideW-1:0]  side_i,
  output logic              valid_o,
  output logic [NumW-1:0]   quo_o,
  output logic [SideW-1:0]  side_o
);

  logic               vld_q  [NumW];
  logic [DenW-1:0]    rem_q  [NumW];
  logic [NumW-1:0]    quo_q  [NumW];
  logic [NumW-1:0]    num_q  [NumW];
  logic [DenW-1:0]    den_q  [NumW];
  logic [SideW-1:0]   side_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic              vld_in;
    logic [DenW-1:0]   rem_in;
    logic [NumW-1:0]   quo_in;
    logic [NumW-1:0]   num_in;
    logic [DenW-1:0]   den_in;
    logic [SideW-1:0]  side_in;
    logic [DenW:0]     t;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign num_in  = num_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign t  = {rem_in, num_in[NumW-1]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DenW'(t - {1'b0, den_in}) : DenW'(t);
        quo_q[k]  <= {quo_in[NumW-2:0], ge};
        num_q[k]  <= num_in << 1;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = quo_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

FILE: design/quadratic_root_solver.sv
`timescale 1ns / 1ps
// Quadratic root solver top level: input, multiply, discriminant and output stages.
// Uses qrs_pkg, qrs_sqrt and qrs_div.
//
// Usage:
//   One request carries signed fixed point coefficients a, b, c (FRAC_BITS
//   fraction bits). One result comes back per request, in order: root kind,
//   the two roots and a saturation flag. A zero a gives the linear root in
//   root_low.
//   The pipeline has 5 + (DATA_WIDTH+1) + (DATA_WIDTH+1+FRAC_BITS) register
//   stages. The square root adds one stage per root bit and the dividers
//   one stage per quotient bit.
//   Throughput is one request per cycle while the pipeline is not frozen.
//   Reset clears all valid bits; the pipeline comes up empty.
//   When out_stall_i holds a waiting result, the whole pipeline freezes and
//   in_stall_o rises; nothing is lost or repeated. Stages with bubbles keep
//   accepting while the output register is empty.
module quadratic_root_solver #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] coef_a_i,
  input  logic [DATA_WIDTH-1:0] coef_b_i,
  input  logic [DATA_WIDTH-1:0] coef_c_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            root_kind_o,
  output logic [DATA_WIDTH-1:0] root_low_o,
  output logic [DATA_WIDTH-1:0] root_high_o,
  output logic                  overflow_o
);

  localparam int W      = DATA_WIDTH;
  localparam int ProdW  = 2 * W;
  localparam int RadW   = 2 * W + 2;
  localparam int RootW  = W + 1;
  localparam int NumSW  = W + 2;
  localparam int NumMW  = W + 1;
  localparam int DenW   = W + 1;
  localparam int DivNW  = NumMW + FRAC_BITS;
  localparam int SqSideW = $bits(qrs_pkg::sq_side_t) + 3 * W;
  localparam int DvSideW = $bits(qrs_pkg::dv_side_t);

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: sign and magnitude
  logic         s1_vld_q;
  logic         s1_an_q, s1_bn_q, s1_cn_q;
  logic [W-1:0] s1_am_q, s1_bm_q, s1_cm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_an_q <= coef_a_i[W-1];
      s1_bn_q <= coef_b_i[W-1];
      s1_cn_q <= coef_c_i[W-1];
      s1_am_q <= coef_a_i[W-1] ? W'(-coef_a_i) : coef_a_i;
      s1_bm_q <= coef_b_i[W-1] ? W'(-coef_b_i) : coef_b_i;
      s1_cm_q <= coef_c_i[W-1] ? W'(-coef_c_i) : coef_c_i;
    end
  end

  // stage 2: products
  logic             s2_vld_q;
  logic             s2_an_q, s2_bn_q, s2_cn_q;
  logic [W-1:0]     s2_am_q, s2_bm_q, s2_cm_q;
  logic [ProdW-1:0] s2_p_q, s2_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_an_q <= s1_an_q;
      s2_bn_q <= s1_bn_q;
      s2_cn_q <= s1_cn_q;
      s2_am_q <= s1_am_q;
      s2_bm_q <= s1_bm_q;
      s2_cm_q <= s1_cm_q;
      s2_p_q  <= ProdW'(s1_bm_q) * ProdW'(s1_bm_q);
      s2_f_q  <= ProdW'(s1_am_q) * ProdW'(s1_cm_q);
    end
  end

  // stage 3: discriminant and root kind
  logic            s3_vld_q;
  logic [RadW-1:0] s3_d_q;
  logic [W-1:0]    s3_am_q, s3_bm_q, s3_cm_q;
  qrs_pkg::sq_side_t s3_side_q;

  logic [RadW-1:0] p_ext, f4;
  logic            d_neg;
  qrs_pkg::kind_e  kind3;

  assign p_ext = RadW'(s2_p_q);
  assign f4    = {s2_f_q, 2'b00};
  assign d_neg = (s2_an_q == s2_cn_q) && (p_ext < f4);

  always_comb begin
    if (s2_am_q == '0) begin
      if (s2_bm_q == '0) begin
        kind3 = (s2_cm_q == '0) ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
      end else begin
        kind3 = qrs_pkg::KIND_ONE;
      end
    end else begin
      kind3 = d_neg ? qrs_pkg::KIND_NONE : qrs_pkg::KIND_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s2_an_q != s2_cn_q) begin
        s3_d_q <= p_ext + f4;
      end else if (d_neg) begin
        s3_d_q <= '0;
      end else begin
        s3_d_q <= p_ext - f4;
      end
      s3_am_q         <= s2_am_q;
      s3_bm_q         <= s2_bm_q;
      s3_cm_q         <= s2_cm_q;
      s3_side_q.kind  <= kind3;
      s3_side_q.a_neg <= s2_an_q;
      s3_side_q.b_neg <= s2_bn_q;
      s3_side_q.c_neg <= s2_cn_q;
    end
  end

  // square root
  logic              sq_vld;
  logic [RootW-1:0]  sq_root;
  logic [SqSideW-1:0] sq_side_out;
  qrs_pkg::sq_side_t sq_side;
  logic [W-1:0]      sq_am, sq_bm, sq_cm;

  qrs_sqrt #(
    .RootW (RootW),
    .SideW (SqSideW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .rad_i   (s3_d_q),
    .side_i  ({s3_side_q, s3_am_q, s3_bm_q, s3_cm_q}),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side_out)
  );

  assign {sq_side, sq_am, sq_bm, sq_cm} = sq_side_out;

  // stage 4: numerators and divider operands
  logic               s4_vld_q;
  logic [DivNW-1:0]   s4_num0_q, s4_num1_q;
  logic [DenW-1:0]    s4_den0_q, s4_den1_q;
  qrs_pkg::dv_side_t  s4_side_q;
  logic               s4_high_neg_q;

  logic [NumSW-1:0] b_s, s_s, n1, n2;
  logic [NumMW-1:0] n1m, n2m;
  logic             lin;

  assign b_s = sq_side.b_neg ? -NumSW'(sq_bm) : NumSW'(sq_bm);
  assign s_s = NumSW'(sq_root);
  assign n1  = -b_s - s_s;
  assign n2  = -b_s + s_s;
  assign n1m = n1[NumSW-1] ? NumMW'(-n1) : NumMW'(n1);
  assign n2m = n2[NumSW-1] ? NumMW'(-n2) : NumMW'(n2);
  assign lin = (sq_side.kind == qrs_pkg::KIND_ONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (lin) begin
        s4_num0_q         <= DivNW'(sq_cm) << FRAC_BITS;
        s4_den0_q         <= DenW'(sq_bm);
        s4_side_q.low_neg <= ~(sq_side.c_neg ^ sq_side.b_neg);
      end else begin
        s4_num0_q         <= DivNW'(n1m) << FRAC_BITS;
        s4_den0_q         <= {sq_am, 1'b0};
        s4_side_q.low_neg <= n1[NumSW-1] ^ sq_side.a_neg;
      end
      s4_num1_q      <= DivNW'(n2m) << FRAC_BITS;
      s4_den1_q      <= {sq_am, 1'b0};
      s4_high_neg_q  <= n2[NumSW-1] ^ sq_side.a_neg;
      s4_side_q.kind <= sq_side.kind;
    end
  end

  // dividers
  logic               dv0_vld, dv1_vld;
  logic [DivNW-1:0]   q0, q1;
  qrs_pkg::dv_side_t  dv0_side;
  logic               dv1_high_neg;

  qrs_div #(
    .NumW  (DivNW),
    .DenW  (DenW),
    .SideW (DvSideW)
  ) u_div_low (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_vld_q),
    .num_i   (s4_num0_q),
    .den_i   (s4_den0_q),
    .side_i  (s4_side_q),
    .valid_o (dv0_vld),
    .quo_o   (q0),
    .side_o  (dv0_side)
  );

  qrs_div #(
    .NumW  (DivNW),
    .DenW  (DenW),
    .SideW (1)
  ) u_div_high (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_vld_q),
    .num_i   (s4_num1_q),
    .den_i   (s4_den1_q),
    .side_i  (s4_high_neg_q),
    .valid_o (dv1_vld),
    .quo_o   (q1),
    .side_o  (dv1_high_neg)
  );

  // stage 5: saturate, sign and output register
  function automatic logic [W:0] pack_root(input logic [DivNW-1:0] q, input logic neg);
    logic [DivNW-1:0] lim;
    logic [DivNW-1:0] m;
    logic             ovf;
    lim = neg ? (DivNW'(1) << (W - 1)) : ((DivNW'(1) << (W - 1)) - DivNW'(1));
    ovf = (q > lim);
    m   = ovf ? lim : q;
    return {ovf, neg ? W'(-m[W-1:0]) : m[W-1:0]};
  endfunction

  logic [W:0] low_pk, high_pk;
  assign low_pk  = pack_root(q0, dv0_side.low_neg);
  assign high_pk = pack_root(q1, dv1_high_neg);

  logic         out_vld_q;
  logic [1:0]   kind_q;
  logic [W-1:0] low_q, high_q;
  logic         ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv0_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q <= dv0_side.kind;
      case (dv0_side.kind)
        qrs_pkg::KIND_ONE: begin
          low_q  <= low_pk[W-1:0];
          high_q <= '0;
          ovf_q  <= low_pk[W];
        end
        qrs_pkg::KIND_TWO: begin
          low_q  <= low_pk[W-1:0];
          high_q <= high_pk[W-1:0];
          ovf_q  <= low_pk[W] | high_pk[W];
        end
        default: begin
          low_q  <= '0;
          high_q <= '0;
          ovf_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign root_kind_o = kind_q;
  assign root_low_o  = low_q;
  assign root_high_o = high_q;
  assign overflow_o  = ovf_q;

`ifndef SYNTHESIS
  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_kind_o == qrs_pkg::KIND_NONE || root_kind_o == qrs_pkg::KIND_INF)
    |-> root_low_o == '0 && root_high_o == '0 && !overflow_o)
    else $error("roots not cleared for no or infinite roots");

  a_one_root_high_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_kind_o == qrs_pkg::KIND_ONE |-> root_high_o == '0)
    else $error("second root set for linear case");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv1_vld == dv0_vld)
    else $error("dividers out of step");
`endif

endmodule

FILE: test/tb_quadratic_root_solver.sv
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_root_solver: directed table, then random requests.
// Uses qrs_pkg; results are predicted per request and compared in order.
module tb_quadratic_root_solver;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int RAND_REQS = 1900;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [DW-1:0] MAXP = 32'h7fff_ffff;
  localparam logic [DW-1:0] MAXN = 32'h8000_0000;
  localparam logic [DW-1:0] ONE = 32'h0001_0000;

  typedef struct packed {
    qrs_pkg::kind_e kind;
    logic [DW-1:0]  low;
    logic [DW-1:0]  high;
    logic           ovf;
  } roots_t;

  typedef struct {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] c;
    logic          known;
    roots_t        res;
  } row_t;

  logic          clk_i, rst_ni;
  logic          in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [DW-1:0] coef_a_i, coef_b_i, coef_c_i;
  logic [1:0]    root_kind_o;
  logic [DW-1:0] root_low_o, root_high_o;
  logic          overflow_o;

  roots_t pending_roots[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     send_done = 0;
  bit     hold_rx = 0;
  bit     quiet = 0;

  quadratic_root_solver #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [DW-1:0] saturate(logic neg, logic [127:0] mag, inout logic ovf);
    logic [127:0] lim;
    logic [DW-1:0] m;
    lim = neg ? 128'(MAXN) : 128'(MAXP);
    if (mag > lim) begin
      m = lim[DW-1:0];
      ovf = 1'b1;
    end else begin
      m = mag[DW-1:0];
    end
    return neg ? -m : m;
  endfunction

  function automatic logic [63:0] isqrt128(logic [127:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_quadratic(logic [DW-1:0] a, logic [DW-1:0] b,
                                             logic [DW-1:0] c);
    roots_t r;
    logic an, bn, cn, n1n, n2n;
    logic [63:0] am, bm, cm, s, n1m, n2m;
    logic [127:0] p, f, d;
    an = a[DW-1]; bn = b[DW-1]; cn = c[DW-1];
    am = an ? 64'(DW'(-a)) : 64'(a);
    bm = bn ? 64'(DW'(-b)) : 64'(b);
    cm = cn ? 64'(DW'(-c)) : 64'(c);
    r = '{qrs_pkg::KIND_NONE, '0, '0, 1'b0};
    if (am == 0) begin
      if (bm == 0) begin
        r.kind = (cm == 0) ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
      end else begin
        r.kind = qrs_pkg::KIND_ONE;
        r.low = saturate(~(cn ^ bn), ({64'd0, cm} << FB) / {64'd0, bm}, r.ovf);
      end
    end else begin
      p = {64'd0, bm} * {64'd0, bm};
      f = ({64'd0, am} * {64'd0, cm}) << 2;
      if (an != cn || p >= f) begin
        d = (an != cn) ? p + f : p - f;
        s = isqrt128(d);
        // -b - s and -b + s in sign/magnitude
        if (bm == 0 || bn) begin
          n1n = (s > bm); n1m = (s > bm) ? s - bm : bm - s;
          n2n = 1'b0;     n2m = bm + s;
        end else begin
          n1n = 1'b1;     n1m = bm + s;
          n2n = (bm > s); n2m = (bm > s) ? bm - s : s - bm;
        end
        if (n1m == 0) n1n = 1'b0;
        if (n2m == 0) n2n = 1'b0;
        r.kind = qrs_pkg::KIND_TWO;
        r.low = saturate(n1n ^ an, ({64'd0, n1m} << FB) / ({64'd0, am} << 1), r.ovf);
        r.high = saturate(n2n ^ an, ({64'd0, n2m} << FB) / ({64'd0, am} << 1), r.ovf);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // random coefficient, mostly moderate magnitudes so roots stay in range
  function automatic logic [DW-1:0] rand_coef();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom();
      2:       return ($urandom_range(1) ? ONE : -ONE) * $urandom_range(1, 8);
      3:       return $urandom_range(1) ? MAXP : MAXN;
      default: return 32'($signed($urandom()) >>> $urandom_range(8, 22));
    endcase
  endfunction

  task automatic send_request(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c,
                              logic known, roots_t res);
    while (!quiet && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    coef_a_i <= a; coef_b_i <= b; coef_c_i <= c;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_roots.push_back(known ? res : solve_quadratic(a, b, c));
    @(negedge clk_i);
  endtask

  initial begin
    row_t rows[$];
    roots_t none, inf;
    none = '{qrs_pkg::KIND_NONE, '0, '0, 1'b0};
    inf = '{qrs_pkg::KIND_INF, '0, '0, 1'b0};
    rows = '{
      '{'0, '0, '0, 1'b1, inf},
      '{'0, '0, ONE, 1'b1, none},
      '{'0, '0, MAXN, 1'b1, none},
      '{'0, ONE, -ONE, 1'b1, '{qrs_pkg::KIND_ONE, ONE, '0, 1'b0}},
      '{'0, 32'd1, MAXP, 1'b1, '{qrs_pkg::KIND_ONE, MAXN, '0, 1'b1}},
      '{'0, MAXN, MAXN, 1'b0, none},
      '{ONE, '0, ONE, 1'b1, none},
      '{ONE, '0, -ONE, 1'b1, '{qrs_pkg::KIND_TWO, -ONE, ONE, 1'b0}},
      '{ONE, -(2 * ONE), ONE, 1'b1, '{qrs_pkg::KIND_TWO, ONE, ONE, 1'b0}},
      '{-ONE, '0, ONE, 1'b0, none},
      '{32'd1, MAXP, '0, 1'b0, none},
      '{MAXP, MAXP, MAXP, 1'b0, none},
      '{MAXN, MAXN, MAXN, 1'b0, none},
      '{MAXN, MAXP, MAXP, 1'b0, none},
      '{32'd1, MAXN, 32'd1, 1'b0, none},
      '{32'hffff_ffff, '0, MAXP, 1'b0, none},
      '{ONE, 3 * ONE, 2 * ONE, 1'b0, none},
      '{3 * ONE, '0, '0, 1'b1, '{qrs_pkg::KIND_TWO, '0, '0, 1'b0}}
    };
    rst_ni = 1'b0; in_valid_i = 1'b0;
    coef_a_i = '0; coef_b_i = '0; coef_c_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (rows[i]) send_request(rows[i].a, rows[i].b, rows[i].c, rows[i].known, rows[i].res);
    for (int n = 0; n < RAND_REQS; n++) begin
      quiet = (n >= 600 && n < 900);
      send_request(rand_coef(), rand_coef(), rand_coef(), 1'b0, none);
    end
    in_valid_i <= 1'b0;
    send_done = 1'b1;
  end

  // receiver stall, with one long hold-off during which the frozen pipeline stalls the sender
  initial begin
    int cyc;
    cyc = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 1000) hold_rx = 1'b1;
      if (cyc == 1400) hold_rx = 1'b0;
      out_stall_i <= hold_rx || (!quiet && $urandom_range(99) < 14);
    end
  end

  always @(posedge clk_i) begin
    roots_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected result", root_low_o, '0);
      end else begin
        want = pending_roots.pop_front();
        if (root_kind_o != want.kind) report_mismatch("root_kind", root_kind_o, want.kind);
        if (root_low_o != want.low) report_mismatch("root_low", root_low_o, want.low);
        if (root_high_o != want.high) report_mismatch("root_high", root_high_o, want.high);
        if (overflow_o != want.ovf) report_mismatch("overflow", overflow_o, want.ovf);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("quadratic_root_solver verification failed");
      $finish;
    end
  end

  initial begin
    wait (send_done);
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_roots.size() == 0) begin
      $display("quadratic_root_solver verification clean");
    end else begin
      $display("quadratic_root_solver verification failed");
    end
    $finish;
  end

endmodule
